FILE: hdl/mjpeg_frame_splitter_assert.svh
// Assertion macros for the frame splitter RTL; msplit_fifo uses them.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MJPEG_FRAME_SPLITTER_ASSERT_SVH
`define MJPEG_FRAME_SPLITTER_ASSERT_SVH

// Same-cycle implication.
`define MSPLIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mjpeg_frame_splitter: same-cycle check failed");

// Next-cycle implication.
`define MSPLIT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mjpeg_frame_splitter: next-cycle check failed");

`endif

FILE: hdl/msplit_pkg.sv
// Types and constants for the MJPEG frame splitter.
// No dependencies; compiled before every other file.
package msplit_pkg;

  localparam int unsigned FRAME_LEN_W = 20;

  localparam logic [7:0] BYTE_FF  = 8'hFF;
  localparam logic [7:0] BYTE_00  = 8'h00;
  localparam logic [7:0] MRK_TEM  = 8'h01;
  localparam logic [7:0] MRK_SOI  = 8'hD8;
  localparam logic [7:0] MRK_EOI  = 8'hD9;
  localparam logic [7:0] MRK_SOS  = 8'hDA;
  localparam logic [7:0] MRK_RST0 = 8'hD0;
  localparam logic [7:0] MRK_RST7 = 8'hD7;

  localparam logic [FRAME_LEN_W-1:0] MAX_LEN_RST = FRAME_LEN_W'(512 * 1024);
  // byte count right after an SOI pair has been forwarded
  localparam logic [FRAME_LEN_W-1:0] OPEN_LEN    = FRAME_LEN_W'(2);
  localparam logic [15:0]            SEG_HDR_LEN = 16'd2;

  // result slots of one queue entry, in output order
  localparam int unsigned SLOT_LEAD  = 0;
  localparam int unsigned SLOT_SOI_FF = 1;
  localparam int unsigned SLOT_SOI_D8 = 2;
  localparam int unsigned SLOT_DATA  = 3;
  localparam int unsigned SLOT_TAIL  = 4;
  localparam int unsigned NUM_SLOTS  = 5;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HUNT_FF,
    PH_BODY,
    PH_BODY_FF,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_SKIP
  } phase_e;

  // job for the back end: up to four results caused by one byte
  typedef struct packed {
    logic                   lead_abort;
    logic                   open_pair;
    logic                   data_en;
    logic                   data_end;
    logic [7:0]             data_byte;
    logic [FRAME_LEN_W-1:0] data_len;
    logic                   tail_abort;
  } entry_t;

endpackage

FILE: hdl/msplit_if.sv
// Valid/ready channel interfaces for the frame splitter byte input and result output.
// Depends on msplit_pkg for the frame length width.
interface msplit_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface msplit_out_if import msplit_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [7:0]             out_byte;
  logic                   frame_start;
  logic                   frame_end;
  logic                   abort;
  logic [FRAME_LEN_W-1:0] frame_bytes;
  logic                   last;

  modport source (output valid, output out_byte, output frame_start, output frame_end,
                  output abort, output frame_bytes, output last, input ready);
  modport sink   (input valid, input out_byte, input frame_start, input frame_end,
                  input abort, input frame_bytes, input last, output ready);
endinterface

FILE: hdl/msplit_fifo.sv
// Small flip-flop queue of parsed entries between the front and back ends.
// Depends on msplit_pkg (entry_t) and the assertion header.
`include "mjpeg_frame_splitter_assert.svh"

module msplit_fifo import msplit_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wr_data_i,
  input  logic   pop_i,
  output entry_t rd_data_o,
  output logic   full_o,
  output logic   empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o    = (count_q == FULL_CNT);
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : AW'(wr_ptr_q + 1'b1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : AW'(rd_ptr_q + 1'b1);
    end
    if (push_i && !pop_i) begin
      count_d = CW'(count_q + 1'b1);
    end else if (!push_i && pop_i) begin
      count_d = CW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  `MSPLIT_ASSERT_IMP(a_no_overflow, push_i, !full_o)
  `MSPLIT_ASSERT_IMP(a_no_underflow, pop_i, !empty_o)
  `MSPLIT_ASSERT_NXT(a_push_lands, push_i && !pop_i, !empty_o)

endmodule

FILE: hdl/msplit_front.sv
// Front end: accepts stream bytes, runs the JPEG marker parser and the
// candidate byte counter, and queues the results each byte causes. Uses msplit_pkg.
module msplit_front import msplit_pkg::*; #(
  parameter int unsigned LEN_BITS = 20
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [FRAME_LEN_W-1:0] cfg_wdata_i,
  msplit_in_if.sink              in_ch,
  input  logic                   full_i,
  output logic                   push_o,
  output entry_t                 entry_o
);

  localparam int unsigned CMP_W = (LEN_BITS > FRAME_LEN_W) ? LEN_BITS : FRAME_LEN_W;

  logic [FRAME_LEN_W-1:0] max_len_q;
  phase_e                 phase_q, phase_d;
  logic [15:0]            seg_left_q, seg_left_d;
  logic [7:0]             len_hi_q, len_hi_d;
  logic                   after_sos_q, after_sos_d;
  logic [LEN_BITS-1:0]    cnt_q, cnt_d;

  logic                   accept;
  logic [7:0]             b;
  logic [LEN_BITS-1:0]    cnt_inc;
  logic [LEN_BITS+FRAME_LEN_W-1:0] len_wide;
  logic                   size_hit;
  logic                   open_hit;
  logic [15:0]            seg;
  logic [15:0]            seg_dec;
  logic                   standalone;
  entry_t                 e;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && !full_i;
  assign b           = in_ch.in_byte;

  // saturating count, then the oversize check on the new count
  assign cnt_inc  = (&cnt_q) ? cnt_q : LEN_BITS'(cnt_q + 1'b1);
  assign len_wide = (LEN_BITS + FRAME_LEN_W)'(cnt_inc);
  assign size_hit = (CMP_W'(cnt_inc) >= CMP_W'(max_len_q)) || (&cnt_inc);
  assign open_hit = (max_len_q <= OPEN_LEN);
  assign seg      = {len_hi_q, b};
  assign seg_dec  = (seg_left_q != '0) ? 16'(seg_left_q - 1'b1) : seg_left_q;
  assign standalone = (b == BYTE_00) || (b == MRK_TEM) ||
                      ((b >= MRK_RST0) && (b <= MRK_RST7));

  always_comb begin
    phase_d     = phase_q;
    seg_left_d  = seg_left_q;
    len_hi_d    = len_hi_q;
    after_sos_d = after_sos_q;
    cnt_d       = cnt_q;
    e           = '0;

    unique case (phase_q)
      PH_HUNT: begin
        if (b == BYTE_FF) phase_d = PH_HUNT_FF;
      end
      PH_HUNT_FF: begin
        if (b == MRK_SOI) begin
          e.open_pair = 1'b1;
        end else if (b != BYTE_FF) begin
          phase_d = PH_HUNT;
        end
      end
      default: begin
        if (phase_q == PH_BODY_FF && b == MRK_SOI) begin
          e.lead_abort = 1'b1;
          e.open_pair  = 1'b1;
        end else if (phase_q == PH_BODY_FF && b == MRK_EOI && !after_sos_q) begin
          e.lead_abort = 1'b1;
          phase_d      = PH_HUNT;
        end else if (phase_q == PH_BODY_FF && b == MRK_EOI) begin
          e.data_en   = 1'b1;
          e.data_end  = 1'b1;
          e.data_byte = b;
          e.data_len  = len_wide[FRAME_LEN_W-1:0];
          phase_d     = PH_HUNT;
        end else begin
          e.data_en   = 1'b1;
          e.data_byte = b;
          cnt_d       = cnt_inc;
          unique case (phase_q)
            PH_BODY: begin
              if (b == BYTE_FF) phase_d = PH_BODY_FF;
            end
            PH_BODY_FF: begin
              if (b == BYTE_FF) begin
                phase_d = PH_BODY_FF;
              end else if (after_sos_q || standalone) begin
                phase_d = PH_BODY;
              end else begin
                if (b == MRK_SOS) after_sos_d = 1'b1;
                phase_d = PH_LEN_HI;
              end
            end
            PH_LEN_HI: begin
              len_hi_d = b;
              phase_d  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
              if (seg < SEG_HDR_LEN) begin
                after_sos_d = 1'b0;
                phase_d     = PH_BODY;
              end else if (seg == SEG_HDR_LEN) begin
                phase_d = PH_BODY;
              end else begin
                seg_left_d = 16'(seg - SEG_HDR_LEN);
                phase_d    = PH_SKIP;
              end
            end
            PH_SKIP: begin
              seg_left_d = seg_dec;
              if (seg_dec == '0) phase_d = PH_BODY;
            end
            default: begin
              phase_d = PH_HUNT;
            end
          endcase
          if (size_hit) begin
            e.tail_abort = 1'b1;
            phase_d      = PH_HUNT;
          end
        end
      end
    endcase

    // a fresh candidate holds FF D8; it may already reach the limit
    if (e.open_pair) begin
      seg_left_d  = '0;
      len_hi_d    = '0;
      after_sos_d = 1'b0;
      cnt_d       = LEN_BITS'(OPEN_LEN);
      phase_d     = PH_BODY;
      if (open_hit) begin
        e.tail_abort = 1'b1;
        phase_d      = PH_HUNT;
      end
    end

    if (in_ch.end_of_stream && phase_d != PH_HUNT && phase_d != PH_HUNT_FF) begin
      e.tail_abort = 1'b1;
    end
    if (in_ch.end_of_stream || phase_d == PH_HUNT) begin
      if (in_ch.end_of_stream) phase_d = PH_HUNT;
      seg_left_d  = '0;
      len_hi_d    = '0;
      after_sos_d = 1'b0;
      cnt_d       = '0;
    end
  end

  assign entry_o = e;
  assign push_o  = accept && (e.lead_abort || e.open_pair || e.data_en || e.tail_abort);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= MAX_LEN_RST;
      phase_q     <= PH_HUNT;
      seg_left_q  <= '0;
      len_hi_q    <= '0;
      after_sos_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_we_i) max_len_q <= cfg_wdata_i;
      if (accept) begin
        phase_q     <= phase_d;
        seg_left_q  <= seg_left_d;
        len_hi_q    <= len_hi_d;
        after_sos_q <= after_sos_d;
        cnt_q       <= cnt_d;
      end
    end
  end

endmodule

FILE: hdl/msplit_back.sv
// Back end: expands the queue head into result beats, one per cycle while the
// output is ready, through a registered output stage. Uses msplit_pkg.
module msplit_back import msplit_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  entry_t       entry_i,
  input  logic         empty_i,
  output logic         pop_o,
  msplit_out_if.source out_ch
);

  logic [NUM_SLOTS-1:0]   sent_q, sent_d;
  logic [NUM_SLOTS-1:0]   slots;
  logic [NUM_SLOTS-1:0]   pick;
  logic                   is_last;
  logic                   load;
  logic                   valid_q, valid_d;

  logic [7:0]             byte_q, byte_d;
  logic                   start_q, start_d;
  logic                   end_q, end_d;
  logic                   abort_q, abort_d;
  logic [FRAME_LEN_W-1:0] len_q, len_d;
  logic                   last_q, last_d;

  always_comb begin
    slots = '0;
    slots[SLOT_LEAD]   = entry_i.lead_abort;
    slots[SLOT_SOI_FF] = entry_i.open_pair;
    slots[SLOT_SOI_D8] = entry_i.open_pair;
    slots[SLOT_DATA]   = entry_i.data_en;
    slots[SLOT_TAIL]   = entry_i.tail_abort;
    slots = slots & ~sent_q;
  end

  // lowest pending slot goes next
  assign pick    = slots & NUM_SLOTS'(~slots + 1'b1);
  assign is_last = ((slots & ~pick) == '0);
  assign load    = !empty_i && (!valid_q || out_ch.ready);
  assign pop_o   = load && is_last;

  always_comb begin
    valid_d = valid_q;
    sent_d  = sent_q;
    byte_d  = byte_q;
    start_d = start_q;
    end_d   = end_q;
    abort_d = abort_q;
    len_d   = len_q;
    last_d  = last_q;
    if (load) begin
      valid_d = 1'b1;
      sent_d  = is_last ? '0 : (sent_q | pick);
      byte_d  = '0;
      start_d = 1'b0;
      end_d   = 1'b0;
      abort_d = 1'b0;
      len_d   = '0;
      last_d  = is_last;
      if (pick[SLOT_LEAD] || pick[SLOT_TAIL]) begin
        abort_d = 1'b1;
      end else if (pick[SLOT_SOI_FF]) begin
        byte_d  = BYTE_FF;
        start_d = 1'b1;
      end else if (pick[SLOT_SOI_D8]) begin
        byte_d = MRK_SOI;
      end else begin
        byte_d = entry_i.data_byte;
        end_d  = entry_i.data_end;
        len_d  = entry_i.data_len;
      end
    end else if (out_ch.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      sent_q  <= '0;
    end else begin
      valid_q <= valid_d;
      sent_q  <= sent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    start_q <= start_d;
    end_q   <= end_d;
    abort_q <= abort_d;
    len_q   <= len_d;
    last_q  <= last_d;
  end

  assign out_ch.valid       = valid_q;
  assign out_ch.out_byte    = byte_q;
  assign out_ch.frame_start = start_q;
  assign out_ch.frame_end   = end_q;
  assign out_ch.abort       = abort_q;
  assign out_ch.frame_bytes = len_q;
  assign out_ch.last        = last_q;

endmodule

FILE: hdl/mjpeg_frame_splitter.sv
// A byte's results pass through the queue and then the registered output stage.
// The parser takes one byte per cycle while the queue is not full; the result beats
// of one byte go out in turn, and the FIFO_DEPTH-entry queue lets the parser run ahead.
// Reset (async, active low): parser hunts for SOI, counters clear, queue empties,
// the length limit register returns to 524288.
// Top level: msplit_front -> msplit_fifo -> msplit_back; uses msplit_pkg, msplit_if.
module mjpeg_frame_splitter import msplit_pkg::*; #(
  parameter int unsigned LEN_BITS   = 20,
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [FRAME_LEN_W-1:0] cfg_wdata_i,
  msplit_in_if.sink              in_ch,
  msplit_out_if.source           out_ch
);

  logic   push;
  logic   pop;
  logic   full;
  logic   empty;
  entry_t wr_entry;
  entry_t rd_entry;

  msplit_front #(
    .LEN_BITS(LEN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (wr_entry)
  );

  msplit_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wr_data_i(wr_entry),
    .pop_i    (pop),
    .rd_data_o(rd_entry),
    .full_o   (full),
    .empty_o  (empty)
  );

  msplit_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .entry_i(rd_entry),
    .empty_i(empty),
    .pop_o  (pop),
    .out_ch (out_ch)
  );

endmodule

FILE: dv/msplit_frame_checker.sv
// Scoreboard for the MJPEG frame splitter: mirrors the byte parser, queues the
// result beats each accepted byte should cause and compares the output beats.
// Depends on msplit_pkg and the channel interfaces in msplit_if.sv.
module msplit_frame_checker import msplit_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [FRAME_LEN_W-1:0] cfg_wdata_i,
  msplit_in_if                   in_ch,
  msplit_out_if                  out_ch,
  output int                     mismatch_cnt,
  output int                     beats_left
);

  localparam logic [FRAME_LEN_W-1:0] LEN_SAT = '1;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0]             data;
    logic                   sof;
    logic                   eof;
    logic                   drop;
    logic [FRAME_LEN_W-1:0] len;
    logic                   last;
  } frame_beat_t;

  frame_beat_t pending_beats[$];

  logic [FRAME_LEN_W-1:0] max_len;
  phase_e                 parse_ph;
  logic [15:0]            seg_left;
  logic [7:0]             len_hi;
  logic                   after_sos;
  logic [FRAME_LEN_W-1:0] cand_len;

  function automatic void push_beat(input logic [7:0] b, input logic sof, input logic eof,
                                    input logic drop, input logic [FRAME_LEN_W-1:0] len);
    frame_beat_t beat;
    beat = '{data: b, sof: sof, eof: eof, drop: drop, len: len, last: 1'b0};
    pending_beats.push_back(beat);
  endfunction

  function automatic void push_drop();
    push_beat(8'h00, 1'b0, 1'b0, 1'b1, '0);
  endfunction

  function automatic void restart_hunt();
    parse_ph  = PH_HUNT;
    seg_left  = '0;
    len_hi    = '0;
    after_sos = 1'b0;
    cand_len  = '0;
  endfunction

  function automatic void bump_len();
    if (cand_len != LEN_SAT) cand_len = cand_len + 1'b1;
  endfunction

  function automatic void check_oversize();
    if (cand_len >= max_len || cand_len == LEN_SAT) begin
      push_drop();
      restart_hunt();
    end
  endfunction

  function automatic void open_frame();
    restart_hunt();
    push_beat(BYTE_FF, 1'b1, 1'b0, 1'b0, '0);
    bump_len();
    push_beat(MRK_SOI, 1'b0, 1'b0, 1'b0, '0);
    bump_len();
    parse_ph = PH_BODY;
    check_oversize();
  endfunction

  // expected beats for one accepted input byte
  function automatic void parse_stream_byte(input logic [7:0] b, input logic eos);
    int          base;
    logic [15:0] seg;
    base = pending_beats.size();
    if (parse_ph == PH_HUNT) begin
      if (b == BYTE_FF) parse_ph = PH_HUNT_FF;
    end else if (parse_ph == PH_HUNT_FF) begin
      if (b == MRK_SOI) open_frame();
      else if (b != BYTE_FF) parse_ph = PH_HUNT;
    end else if (parse_ph == PH_BODY_FF && b == MRK_SOI) begin
      push_drop();
      open_frame();
    end else if (parse_ph == PH_BODY_FF && b == MRK_EOI && !after_sos) begin
      push_drop();
      restart_hunt();
    end else if (parse_ph == PH_BODY_FF && b == MRK_EOI) begin
      bump_len();
      push_beat(b, 1'b0, 1'b1, 1'b0, cand_len);
      restart_hunt();
    end else begin
      bump_len();
      push_beat(b, 1'b0, 1'b0, 1'b0, '0);
      case (parse_ph)
        PH_BODY: begin
          if (b == BYTE_FF) parse_ph = PH_BODY_FF;
        end
        PH_BODY_FF: begin
          // repeated FF is fill and keeps us waiting for the marker code
          if (b != BYTE_FF) begin
            if (after_sos || b == BYTE_00 || b == MRK_TEM ||
                (b >= MRK_RST0 && b <= MRK_RST7)) begin
              parse_ph = PH_BODY;
            end else begin
              if (b == MRK_SOS) after_sos = 1'b1;
              parse_ph = PH_LEN_HI;
            end
          end
        end
        PH_LEN_HI: begin
          len_hi   = b;
          parse_ph = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          seg = {len_hi, b};
          if (seg < SEG_HDR_LEN) begin
            after_sos = 1'b0;
            parse_ph  = PH_BODY;
          end else if (seg == SEG_HDR_LEN) begin
            parse_ph = PH_BODY;
          end else begin
            seg_left = seg - SEG_HDR_LEN;
            parse_ph = PH_SKIP;
          end
        end
        default: begin
          if (seg_left != 0) seg_left = seg_left - 1'b1;
          if (seg_left == 0) parse_ph = PH_BODY;
        end
      endcase
      check_oversize();
    end
    if (eos) begin
      if (parse_ph >= PH_BODY) push_drop();
      restart_hunt();
    end
    if (pending_beats.size() > base) pending_beats[pending_beats.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frame_beat_t got;
    frame_beat_t want;
    if (!rst_ni) begin
      max_len = MAX_LEN_RST;
      restart_hunt();
      pending_beats.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_we_i) max_len = cfg_wdata_i;
      if (in_ch.valid && in_ch.ready) parse_stream_byte(in_ch.in_byte, in_ch.end_of_stream);
      if (out_ch.valid && out_ch.ready) begin
        got = '{data: out_ch.out_byte, sof: out_ch.frame_start, eof: out_ch.frame_end,
                drop: out_ch.abort, len: out_ch.frame_bytes, last: out_ch.last};
        if (pending_beats.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("[%0t] unexpected beat: byte %h sof %b eof %b abort %b len %0d last %b",
                     $realtime, got.data, got.sof, got.eof, got.drop, got.len, got.last);
        end else begin
          want = pending_beats.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS) begin
              $display("[%0t] beat mismatch", $realtime);
              $display("  exp: byte %h sof %b eof %b abort %b len %0d last %b",
                       want.data, want.sof, want.eof, want.drop, want.len, want.last);
              $display("  got: byte %h sof %b eof %b abort %b len %0d last %b",
                       got.data, got.sof, got.eof, got.drop, got.len, got.last);
            end
          end
        end
      end
    end
    beats_left = pending_beats.size();
  end

endmodule

FILE: dv/tb_mjpeg_frame_splitter.sv
// Testbench top for mjpeg_frame_splitter: builds JPEG-like byte streams, drives
// the input channel and output back-pressure, and reports the verdict.
// Depends on msplit_pkg, msplit_if.sv and msplit_frame_checker.
module tb_mjpeg_frame_splitter;
  import msplit_pkg::*;

  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned BYTES_PER_PHASE = 50;
  localparam int unsigned STALL_LIMIT     = 3000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam logic [7:0]  MRK_APP0        = 8'hE0;
  localparam logic [7:0]  MRK_DHT         = 8'hC4;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } stream_byte_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [FRAME_LEN_W-1:0] cfg_wdata_i;
  int                     mismatch_cnt;
  int                     beats_left;
  int                     tx_gap_pct;
  int                     rx_stall_pct;
  int                     rx_hold_left;
  stream_byte_t           byte_q[$];

  msplit_in_if  in_ch ();
  msplit_out_if out_ch ();

  mjpeg_frame_splitter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  msplit_frame_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .mismatch_cnt (mismatch_cnt),
    .beats_left   (beats_left)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void put(input logic [7:0] b, input logic eos = 1'b0);
    byte_q.push_back('{data: b, eos: eos});
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_segment(input logic [7:0] mk, input int unsigned len);
    put(BYTE_FF);
    put(mk);
    put(8'(len >> 8));
    put(8'(len));
    for (int unsigned i = 2; i < len; i++) put(rand_byte());
  endfunction

  function automatic logic [7:0] header_marker();
    logic [7:0] mk;
    mk = 8'($urandom_range(8'hC0, 8'hFE));
    // keep RSTn, SOI, EOI and SOS out of the header segments
    if (mk >= MRK_RST0 && mk <= MRK_SOS) mk = MRK_APP0 | (mk & 8'h0F);
    return mk;
  endfunction

  function automatic int unsigned seg_len();
    // mostly short, now and then the degenerate lengths below two
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 7);
  endfunction

  function automatic void add_header();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: begin put(BYTE_FF); put(MRK_TEM); end
        1: begin put(BYTE_FF); put(MRK_RST0 + 8'($urandom_range(0, 7))); end
        2: begin put(BYTE_FF); put(BYTE_FF); end
        default: add_segment(header_marker(), seg_len());
      endcase
    end
  endfunction

  function automatic void add_frame();
    put(BYTE_FF);
    put(MRK_SOI);
    add_header();
    add_segment(MRK_SOS, $urandom_range(2, 6));
    repeat ($urandom_range(0, 16)) begin
      case ($urandom_range(0, 7))
        0: begin put(BYTE_FF); put(BYTE_00); end
        1: begin put(BYTE_FF); put(MRK_RST0 + 8'($urandom_range(0, 7))); end
        2: begin put(BYTE_FF); put(BYTE_FF); end
        3: begin put(BYTE_FF); put(8'($urandom_range(8'hDA, 8'hFE))); end
        default: put(8'($urandom_range(0, 254)));
      endcase
    end
    put(BYTE_FF);
    put(MRK_EOI, $urandom_range(0, 7) == 0);
  endfunction

  function automatic void add_broken();
    int unsigned n;
    case ($urandom_range(0, 4))
      0: begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0) put(BYTE_FF);
          else put(rand_byte());
        end
      end
      1: begin
        // stream ends inside a candidate
        put(BYTE_FF);
        put(MRK_SOI);
        add_header();
        n = $urandom_range(0, 6);
        repeat (n) put(rand_byte());
        put(rand_byte(), 1'b1);
      end
      2: begin
        put(BYTE_FF);
        put(MRK_SOI);
        add_header();
        put(BYTE_FF);
        put(MRK_EOI);
      end
      3: begin
        put(BYTE_FF);
        put(MRK_SOI);
        add_header();
        add_frame();
      end
      default: begin
        // arbitrary segment length, usually cut short by end of stream
        put(BYTE_FF);
        put(MRK_SOI);
        put(BYTE_FF);
        put(header_marker());
        put(rand_byte());
        put(rand_byte());
        repeat ($urandom_range(0, 10)) put(rand_byte());
        put(rand_byte(), 1'b1);
      end
    endcase
  endfunction

  function automatic void load_directed();
    put(BYTE_00);
    put(BYTE_FF);
    put(BYTE_FF);
    put(MRK_SOI);
    put(BYTE_FF);
    put(MRK_TEM);
    put(BYTE_FF);
    put(BYTE_FF);
    put(MRK_APP0);
    put(8'h00);
    put(8'h01);
    put(BYTE_FF);
    put(MRK_SOS);
    put(8'h00);
    put(8'h02);
    put(BYTE_FF);
    put(MRK_RST0 + 8'd3);
    put(BYTE_FF);
    put(MRK_DHT);
    put(BYTE_FF);
    put(BYTE_FF);
    put(MRK_EOI);
    // SOI inside a candidate, then EOI before any SOS
    put(BYTE_FF);
    put(MRK_SOI);
    put(BYTE_FF);
    put(MRK_SOI);
    put(BYTE_FF);
    put(MRK_EOI, 1'b1);
  endfunction

  function automatic void load_random(input int unsigned n);
    int unsigned target;
    target = byte_q.size() + n;
    while (byte_q.size() < target) begin
      if ($urandom_range(0, 9) < 7) add_frame();
      else add_broken();
    end
  endfunction

  function automatic logic [FRAME_LEN_W-1:0] phase_limit(input int unsigned ph);
    case (ph)
      1:       return FRAME_LEN_W'(16);
      2:       return '0;
      3:       return '1;
      4:       return FRAME_LEN_W'(24);
      5:       return FRAME_LEN_W'(300);
      default: return MAX_LEN_RST;
    endcase
  endfunction

  task automatic send_stream();
    stream_byte_t s;
    while (byte_q.size() > 0) begin
      if ($urandom_range(0, 99) < tx_gap_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end else begin
        s = byte_q.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.in_byte       <= s.data;
        in_ch.end_of_stream <= s.eos;
        @(posedge clk_i);
        while (!in_ch.ready) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    while (beats_left != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [FRAME_LEN_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // output side back-pressure; a requested hold is counted down here
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.end_of_stream <= 1'b0;
    tx_gap_pct   = 7;
    rx_stall_pct = 68;
    rx_hold_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_directed();
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph != 0) write_max_len(phase_limit(ph));
      if (ph < 2) begin
        tx_gap_pct   = 7;
        rx_stall_pct = 68;
      end else if (ph < 4) begin
        tx_gap_pct   = 68;
        rx_stall_pct = 7;
      end else begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      // long receiver hold while bytes keep coming: queue fills, input stalls
      if (ph == NUM_PHASES - 1) rx_hold_left = HOLD_CYCLES;
      load_random(BYTES_PER_PHASE);
      send_stream();
      settle();
    end
    if (mismatch_cnt == 0 && beats_left == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
